/* design/ssa_pkg.sv */
// ssa_pkg: shared types and constants for the reaction selector.
// No dependencies.
`timescale 1ns / 1ps
package ssa_pkg;

  localparam int RATE_W   = 24;
  localparam int IDX_W    = 3;
  localparam int NUM_REGS = 7;
  localparam int DVD_W    = 37;
  localparam logic [27:0] LN2_Q28 = 28'hB17217F;
  localparam int SQ_STEPS = 30;

  localparam logic [2:0] REG_RATE_ZERO  = 3'd0;
  localparam logic [2:0] REG_RATE_ONE   = 3'd1;
  localparam logic [2:0] REG_RATE_TWO   = 3'd2;
  localparam logic [2:0] REG_RATE_THREE = 3'd3;
  localparam logic [2:0] REG_RATE_FOUR  = 3'd4;
  localparam logic [2:0] REG_RATE_FIVE  = 3'd5;
  localparam logic [2:0] REG_ACTIVE     = 3'd6;

  localparam logic KIND_COUNT    = 1'b0;
  localparam logic KIND_SCHEDULE = 1'b1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_PROP  = 11'b00000000010,
    S_THRHI = 11'b00000000100,
    S_THRLO = 11'b00000001000,
    S_SEL   = 11'b00000010000,
    S_NORM  = 11'b00000100000,
    S_SQ    = 11'b00001000000,
    S_LNLO  = 11'b00010000000,
    S_LNHI  = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

endpackage

/* design/ssa_reaction_selector.sv */
// ssa_reaction_selector: direct-method stochastic simulation step for unimolecular reactions.
// Depends on ssa_pkg.
`timescale 1ns / 1ps
// Usage:
//  in_*  : stream of input words. tuser = kind (0 writes a reactant count,
//          1 schedules). A count write gives no result.
//  out_* : one result word per schedule word: tuser = reaction_found,
//          tdata = chosen_reaction and Q16.16 wait_time.
//  cfg_* : APB-style registers: six 24-bit rates at 0x00..0x14, active
//          reaction count at 0x18. Write only while the block is idle.
// Sequence: a schedule word runs through one shared 32x32 multiplier and a
//  radix-2 divider under a sequencer: propensity, the THRHI and THRLO
//  threshold steps, selection, normalise, squaring, the LNLO and LNHI ln
//  steps, divide and output. When the total is zero it goes from propensity
//  straight to output; when the time word is zero it goes from selection
//  straight to output. The next word is taken once the result is loaded
//  into the output register. in_tready is low while a word is in work.
// Reset clears counts, rates and the sequencer. A stalled out_tready holds
//  the result in the output register; the next schedule word waits at its
//  final cycle until the register is free.
module ssa_reaction_selector
  import ssa_pkg::*;
#(
  parameter int MAX_REACTIONS = 6,
  parameter int COUNT_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // reaction_slot[2:0], reactant_total[18:3],
                                  // rand_select[50:19], rand_time[82:51], zeros
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // chosen_reaction[2:0], wait_time[34:3], zeros
  output logic        out_tuser,  // reaction_found
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int TOT_W = COUNT_BITS + RATE_W + 3;

  state_t state_r, state_nxt;

  logic [COUNT_BITS-1:0] counts_r [MAX_REACTIONS];
  logic [RATE_W-1:0]     rates_r  [6];
  logic [2:0]            active_r;
  logic [TOT_W-1:0]      cum_r    [MAX_REACTIONS];
  logic [TOT_W-1:0]      total_r, thr_r;
  logic [IDX_W-1:0]      idx_r, chosen_r, nact;
  logic [31:0]           u1_r, u2_r, x_r;
  logic [4:0]            p_r, lead;
  logic [29:0]           frac_r;
  logic [5:0]            cnt_r;
  logic [63:0]           ln_r;
  logic [DVD_W-1:0]      dvd_r, q_r;
  logic [TOT_W-1:0]      rem_r;
  logic [TOT_W:0]        rem_t;
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           prod, ln_sum;
  logic [35:0]           n_val;
  logic [32:0]           sq_t;
  logic                  out_valid_r, out_found_r;
  logic [2:0]            out_chosen_r;
  logic [31:0]           out_wait_r;
  logic                  load_out, cfg_wr;
  logic [2:0]            cfg_idx, in_slot;

  assign in_slot   = in_tdata[2:0];
  assign in_tready = (state_r == S_IDLE);
  assign cfg_pready = 1'b1;
  assign cfg_idx   = cfg_paddr[4:2];
  assign cfg_wr    = cfg_psel & cfg_penable & cfg_pwrite;

  assign nact = (active_r > 3'(MAX_REACTIONS)) ? IDX_W'(MAX_REACTIONS) : active_r;

  always_comb begin
    lead = 5'd0;
    for (int b = 0; b < 32; b++) begin
      if (u2_r[b]) lead = 5'(b);
    end
  end

  assign n_val  = ({31'd0, 5'd0} | (36'(6'd32 - {1'b0, p_r}) << 30)) - 36'(frac_r);
  assign sq_t   = prod[63:31];
  assign ln_sum = ln_r + (prod << 18);
  assign rem_t  = {rem_r, dvd_r[DVD_W-1]};

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      S_PROP: begin
        mul_a = 32'(counts_r[idx_r]);
        mul_b = 32'(rates_r[idx_r]);
      end
      S_THRHI: begin
        mul_a = 32'(total_r >> 32);
        mul_b = u1_r;
      end
      S_THRLO: begin
        mul_a = total_r[31:0];
        mul_b = u1_r;
      end
      S_SQ: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      S_LNLO: begin
        mul_a = 32'(n_val[17:0]);
        mul_b = 32'(LN2_Q28);
      end
      S_LNHI: begin
        mul_a = 32'(n_val[35:18]);
        mul_b = 32'(LN2_Q28);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tuser == KIND_SCHEDULE) state_nxt = S_PROP;
      end
      S_PROP: begin
        if (idx_r >= nact) state_nxt = (total_r == '0) ? S_DONE : S_THRHI;
      end
      S_THRHI: state_nxt = S_THRLO;
      S_THRLO: state_nxt = S_SEL;
      S_SEL: begin
        if (cum_r[idx_r] > thr_r || idx_r >= nact - 3'd1)
          state_nxt = (u2_r == 32'd0) ? S_DONE : S_NORM;
      end
      S_NORM: state_nxt = S_SQ;
      S_SQ: begin
        if (cnt_r == 6'(SQ_STEPS - 1)) state_nxt = S_LNLO;
      end
      S_LNLO: state_nxt = S_LNHI;
      S_LNHI: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == 6'(DVD_W - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= 3'd0;
      for (int i = 0; i < MAX_REACTIONS; i++) counts_r[i] <= '0;
      for (int i = 0; i < 6; i++) rates_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_RATE_ZERO:  rates_r[0] <= cfg_pwdata[RATE_W-1:0];
          REG_RATE_ONE:   rates_r[1] <= cfg_pwdata[RATE_W-1:0];
          REG_RATE_TWO:   rates_r[2] <= cfg_pwdata[RATE_W-1:0];
          REG_RATE_THREE: rates_r[3] <= cfg_pwdata[RATE_W-1:0];
          REG_RATE_FOUR:  rates_r[4] <= cfg_pwdata[RATE_W-1:0];
          REG_RATE_FIVE:  rates_r[5] <= cfg_pwdata[RATE_W-1:0];
          REG_ACTIVE:     active_r   <= cfg_pwdata[2:0];
          default: ;
        endcase
      end
      if (state_r == S_IDLE && in_tvalid && in_tuser == KIND_COUNT
          && in_slot < 3'(MAX_REACTIONS)) begin
        for (int i = 0; i < MAX_REACTIONS; i++) begin
          if (in_slot == 3'(i)) counts_r[i] <= COUNT_BITS'(in_tdata[18:3]);
        end
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        idx_r    <= '0;
        total_r  <= '0;
        chosen_r <= '0;
        u1_r     <= in_tdata[50:19];
        u2_r     <= in_tdata[82:51];
      end
      S_PROP: begin
        if (idx_r < nact) begin
          total_r        <= total_r + TOT_W'(prod);
          cum_r[idx_r]   <= total_r + TOT_W'(prod);
          idx_r          <= idx_r + 3'd1;
        end
      end
      S_THRHI: begin
        thr_r <= TOT_W'(prod);
        idx_r <= '0;
      end
      S_THRLO: thr_r <= thr_r + TOT_W'(prod[63:32]);
      S_SEL: begin
        chosen_r <= idx_r;
        idx_r    <= idx_r + 3'd1;
      end
      S_NORM: begin
        p_r    <= lead;
        x_r    <= u2_r << (~lead);
        frac_r <= '0;
        cnt_r  <= '0;
      end
      S_SQ: begin
        x_r    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        frac_r <= {frac_r[28:0], sq_t[32]};
        cnt_r  <= cnt_r + 6'd1;
      end
      S_LNLO: ln_r <= prod;
      S_LNHI: begin
        dvd_r <= {ln_sum[62:30], 4'd0};
        rem_r <= '0;
        q_r   <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (rem_t >= {1'b0, total_r}) begin
          rem_r <= TOT_W'(rem_t - {1'b0, total_r});
          q_r   <= {q_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_t[TOT_W-1:0];
          q_r   <= {q_r[DVD_W-2:0], 1'b0};
        end
      end
      S_DONE: begin
        if (load_out) begin
          if (total_r == '0) begin
            out_found_r  <= 1'b0;
            out_chosen_r <= 3'd0;
            out_wait_r   <= 32'd0;
          end else begin
            out_found_r  <= 1'b1;
            out_chosen_r <= chosen_r;
            if (u2_r == 32'd0 || q_r[DVD_W-1:32] != '0) out_wait_r <= 32'hFFFFFFFF;
            else out_wait_r <= q_r[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RATE_ZERO:  cfg_prdata = 32'(rates_r[0]);
      REG_RATE_ONE:   cfg_prdata = 32'(rates_r[1]);
      REG_RATE_TWO:   cfg_prdata = 32'(rates_r[2]);
      REG_RATE_THREE: cfg_prdata = 32'(rates_r[3]);
      REG_RATE_FOUR:  cfg_prdata = 32'(rates_r[4]);
      REG_RATE_FIVE:  cfg_prdata = 32'(rates_r[5]);
      REG_ACTIVE:     cfg_prdata = 32'(active_r);
      default:        cfg_prdata = 32'd0;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {5'd0, out_wait_r, out_chosen_r};

endmodule

/* verif/testbench.sv */
// Testbench for ssa_reaction_selector: drives count and schedule words, predicts
// the chosen reaction and Q16.16 waiting time, and checks every result word.
// Depends on ssa_pkg and the ssa_reaction_selector RTL.
`timescale 1ns / 1ps
module testbench;
  import ssa_pkg::*;

  localparam int NREACT = 6;
  localparam int WATCH_LIMIT = 200000;

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic [15:0] cnt;
    logic [31:0] usel;
    logic [31:0] utime;
  } word_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  chosen;
    logic [31:0] wait_t;
  } sched_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [87:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid, out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic out_tuser;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic cfg_pready;
  logic in_acc = 1'b0;

  ssa_reaction_selector dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [23:0] rate_m [NREACT];
  logic [2:0]  active_m;
  logic [15:0] count_m [NREACT];

  word_t  pending_q[$];
  sched_t sched_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  int hold_off = 0;
  int quiet = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic void queue_word(input word_t w);
    pending_q = {pending_q, w};
  endfunction

  function automatic logic [63:0] neg_ln(input logic [31:0] u);
    int p;
    logic [63:0] x, frac, n;
    logic [127:0] prod;
    p = 31;
    while (p > 0 && u[p] == 1'b0) p--;
    x = 64'(u) << (31 - p);
    frac = '0;
    for (int i = 0; i < SQ_STEPS; i++) begin
      x = (x * x) >> 31;
      frac = frac << 1;
      if (x >= 64'h1_0000_0000) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    n = (64'(32 - p) << 30) - frac;
    prod = 128'(n) * 128'(LN2_Q28);
    return 64'(prod >> 30);
  endfunction

  function automatic void predict_word(input word_t w);
    logic [63:0] cum [NREACT];
    logic [63:0] total, thr, wt;
    int nact;
    sched_t r;
    if (w.kind == KIND_COUNT) begin
      if (w.slot < NREACT) count_m[w.slot] = w.cnt;
      return;
    end
    nact = (active_m > NREACT) ? NREACT : active_m;
    total = '0;
    for (int i = 0; i < nact; i++) begin
      total += 64'(count_m[i]) * 64'(rate_m[i]);
      cum[i] = total;
    end
    r = '0;
    if (total != 0) begin
      thr = (total >> 32) * 64'(w.usel) + (((total & 64'hFFFF_FFFF) * 64'(w.usel)) >> 32);
      for (int i = 0; i < nact; i++)
        if (cum[i] > thr) begin
          r.chosen = 3'(i);
          break;
        end
      if (w.utime == 0) wt = 64'hFFFF_FFFF;
      else begin
        wt = (neg_ln(w.utime) << 4) / total;
        if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;
      end
      r.found = 1'b1;
      r.wait_t = wt[31:0];
    end
    sched_q = {sched_q, r};
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) begin
        predict_word(pending_q.pop_front());
      end
      if ((!in_tvalid || in_acc) && pending_q.size() > 0
          && $urandom_range(99) >= send_idle) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_q[0].kind;
        in_tdata <= {5'd0, pending_q[0].utime, pending_q[0].usel,
                     pending_q[0].cnt, pending_q[0].slot};
      end else if (!in_tvalid || in_acc) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      in_acc <= in_tvalid && in_tready;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (out_tvalid && out_tready) begin
        if (sched_q.size() == 0) report("result word with nothing expected");
        else begin
          sched_t e;
          e = sched_q.pop_front();
          if (out_tuser !== e.found)
            report($sformatf("found %b exp %b", out_tuser, e.found));
          if (out_tdata[2:0] !== e.chosen)
            report($sformatf("chosen %0d exp %0d", out_tdata[2:0], e.chosen));
          if (out_tdata[34:3] !== e.wait_t)
            report($sformatf("wait %h exp %h", out_tdata[34:3], e.wait_t));
        end
      end
      if (quiet >= WATCH_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx == REG_ACTIVE) active_m = val[2:0];
    else rate_m[idx] = val[23:0];
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_tvalid && sched_q.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_rates(input int mode, input logic [2:0] nact);
    logic [31:0] v;
    for (int i = 0; i < NREACT; i++) begin
      case (mode)
        0: v = 32'hFF_FFFF;
        1: v = 32'd0;
        2: v = $urandom_range(32'h3_0000);
        default: v = $urandom;
      endcase
      write_reg(3'(i), v);
    end
    write_reg(REG_ACTIVE, {29'($urandom_range(32'h1FFF_FFFF)), nact});
  endtask

  function automatic word_t rand_word(input int pct_sched);
    word_t w;
    w.kind = ($urandom_range(99) < pct_sched) ? KIND_SCHEDULE : KIND_COUNT;
    w.slot = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    case ($urandom_range(3))
      0: w.cnt = 16'hFFFF;
      1: w.cnt = 16'($urandom_range(3));
      default: w.cnt = 16'($urandom);
    endcase
    w.usel = $urandom;
    w.utime = ($urandom_range(31) == 0) ? 32'($urandom_range(2)) : $urandom;
    if ($urandom_range(15) == 0) w.usel = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'd0;
    return w;
  endfunction

  function automatic word_t mk(input logic k, input logic [2:0] s, input logic [15:0] c,
                                input logic [31:0] a, input logic [31:0] b);
    word_t w;
    w = {k, s, c, a, b};
    return w;
  endfunction

  initial begin
    for (int i = 0; i < NREACT; i++) begin
      rate_m[i] = '0;
      count_m[i] = '0;
    end
    active_m = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: total zero with reset state, then extremes
    queue_word(mk(KIND_SCHEDULE, 0, 0, 32'h8000_0000, 32'h8000_0000));
    drain();
    set_rates(0, 3'd7);
    queue_word(mk(KIND_SCHEDULE, 0, 0, 0, 1));
    for (int i = 0; i < 8; i++)
      queue_word(mk(KIND_COUNT, 3'(i), 16'hFFFF, 0, 1));
    queue_word(mk(KIND_SCHEDULE, 0, 0, 32'hFFFF_FFFF, 32'd1));
    queue_word(mk(KIND_SCHEDULE, 0, 0, 32'd0, 32'hFFFF_FFFF));
    queue_word(mk(KIND_SCHEDULE, 0, 0, 32'h2AAA_AAAB, 32'd0));
    queue_word(mk(KIND_SCHEDULE, 0, 0, 32'hD555_5555, 32'h8000_0000));
    queue_word(mk(KIND_COUNT, 3'd0, 16'd0, 0, 1));
    queue_word(mk(KIND_COUNT, 3'd2, 16'd1, 0, 1));
    queue_word(mk(KIND_SCHEDULE, 0, 0, 32'h0000_0001, 32'h0000_0002));
    drain();
    set_rates(2, 3'd1);
    queue_word(mk(KIND_COUNT, 3'd0, 16'd1, 0, 1));
    queue_word(mk(KIND_SCHEDULE, 0, 0, 32'h1234_5678, 32'h0000_0001));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 36 : (ph < 4) ? 74 : 0;
      recv_idle = (ph < 2) ? 74 : (ph < 4) ? 36 : 0;
      set_rates(ph % 4, (ph == 1) ? 3'd0 : (ph == 5) ? 3'd6 : 3'($urandom_range(7, 1)));
      if (ph == 2) hold_off = 600;
      for (int i = 0; i < 200; i++) queue_word(rand_word(60));
      drain();
    end

    send_idle = 0;
    recv_idle = 0;
    repeat (200) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
design/ssa_pkg.sv
design/ssa_reaction_selector.sv
verif/testbench.sv
